>>> rtl/thl_pkg.sv
// ----------------------------------------------------------------------------
// thl_pkg
// Types, curve tables and range limits for the thermistor table linearizer.
// ----------------------------------------------------------------------------
package thl_pkg;

  localparam int SEGMENTS  = 16;
  localparam int PTS       = SEGMENTS + 1;
  localparam int SEG_W     = $clog2(SEGMENTS);
  localparam int IDX_W     = $clog2(PTS);
  localparam int CURVES    = 5;
  localparam int CV_W      = $clog2(CURVES);
  localparam int RANGES    = 10;
  localparam int RNG_W     = 4;
  localparam int PT_W      = 12;
  localparam int CODE_W    = 12;
  localparam int TEMP_W    = 13;
  localparam int STEP_W    = 8;
  localparam int PCT_W     = 7;
  localparam int HUNDRED   = 100;

  // serial divider: quotient bits produced one per cycle
  localparam int DIV_STEPS = 8;
  localparam int DIVS_W    = PT_W;
  localparam int DIVD_W    = DIVS_W + DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PREP,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_DONE
  } thl_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
  } div_stat_t;

  typedef struct packed {
    logic             done;
    logic [SEG_W-1:0] seg;
  } srch_stat_t;

  localparam logic [PT_W-1:0] CURVE_ROM [CURVES][PTS] = '{
    '{12'd932, 12'd844, 12'd716, 12'd564, 12'd412, 12'd284, 12'd192, 12'd128,
      12'd84,  12'd56,  12'd40,  12'd28,  12'd20,  12'd16,  12'd12,  12'd8,
      12'd4},
    '{12'd3918, 12'd3818, 12'd3650, 12'd3408, 12'd3050, 12'd2670, 12'd2218,
      12'd1772, 12'd1362, 12'd1040, 12'd758,  12'd550,  12'd406,  12'd283,
      12'd200,  12'd137,  12'd91},
    '{12'd932, 12'd860, 12'd760, 12'd640, 12'd508, 12'd384, 12'd280, 12'd200,
      12'd140, 12'd100, 12'd72,  12'd52,  12'd36,  12'd28,  12'd20,  12'd16,
      12'd12},
    '{12'd994, 12'd971, 12'd935, 12'd880, 12'd798, 12'd714, 12'd612, 12'd510,
      12'd415, 12'd339, 12'd272, 12'd224, 12'd190, 12'd161, 12'd142, 12'd127,
      12'd115},
    '{12'd984, 12'd952, 12'd908, 12'd844, 12'd764, 12'd668, 12'd564, 12'd460,
      12'd368, 12'd288, 12'd220, 12'd168, 12'd132, 12'd100, 12'd76,  12'd60,
      12'd48}
  };

  localparam logic signed [TEMP_W-1:0] LOW_LIM [RANGES] = '{
    -13'sd400, -13'sd400, -13'sd400, -13'sd400, -13'sd400,
    -13'sd400, -13'sd400, -13'sd400, -13'sd500, -13'sd580
  };

  localparam logic signed [TEMP_W-1:0] HIGH_LIM [RANGES] = '{
    13'sd1500, 13'sd3020, 13'sd1200, 13'sd2480, 13'sd1200,
    13'sd2480, 13'sd1200, 13'sd2480, 13'sd1100, 13'sd2300
  };

  localparam logic [STEP_W-1:0] SEG_STEP [RANGES] = '{
    8'd119, 8'd214, 8'd100, 8'd180, 8'd100,
    8'd180, 8'd100, 8'd180, 8'd100, 8'd180
  };

  // sensor range 0 acts as 1, 11..15 as 10
  function automatic logic [RNG_W-1:0] range_sel(input logic [RNG_W-1:0] r);
    logic [RNG_W-1:0] s;
    if (r inside {[1:RANGES]}) begin
      s = r - RNG_W'(1);
    end else if (r == '0) begin
      s = '0;
    end else begin
      s = RNG_W'(RANGES - 1);
    end
    return s;
  endfunction

  function automatic logic [PT_W-1:0] curve_pt(input logic [CV_W-1:0]  cv,
                                               input logic [IDX_W-1:0] idx);
    logic [PT_W-1:0] p;
    if (cv < CV_W'(CURVES) && idx < IDX_W'(PTS)) begin
      p = CURVE_ROM[cv][idx];
    end else begin
      p = '0;
    end
    return p;
  endfunction

  function automatic logic signed [TEMP_W-1:0] low_lim(input logic [RNG_W-1:0] s);
    logic signed [TEMP_W-1:0] v;
    if (s < RNG_W'(RANGES)) begin
      v = LOW_LIM[s];
    end else begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic signed [TEMP_W-1:0] high_lim(input logic [RNG_W-1:0] s);
    logic signed [TEMP_W-1:0] v;
    if (s < RNG_W'(RANGES)) begin
      v = HIGH_LIM[s];
    end else begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] seg_step(input logic [RNG_W-1:0] s);
    logic [STEP_W-1:0] v;
    if (s < RNG_W'(RANGES)) begin
      v = SEG_STEP[s];
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

>>> rtl/thl_search.sv
// ----------------------------------------------------------------------------
// thl_search
// Bit-serial segment search: one bit of the segment index per cycle, MSB
// first, one curve point compared per cycle.
// ----------------------------------------------------------------------------
module thl_search import thl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CV_W-1:0]   cv,
  input  logic [CODE_W-1:0] code,
  output srch_stat_t        stat
);

  logic             busy_r;
  logic             done_r;
  logic [SEG_W-1:0] mask_r;
  logic [SEG_W-1:0] seg_r;
  logic [SEG_W-1:0] trial;
  logic [PT_W-1:0]  pt;
  logic             above;

  // seg = count of points past the first that lie above the code
  assign trial = seg_r | mask_r;
  assign pt    = curve_pt(cv, {1'b0, trial});
  assign above = pt > code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mask_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        mask_r <= {1'b1, {(SEG_W-1){1'b0}}};
      end else if (busy_r) begin
        mask_r <= mask_r >> 1;
        if (mask_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      seg_r <= '0;
    end else if (busy_r && above) begin
      seg_r <= trial;
    end
  end

  assign stat.done = done_r;
  assign stat.seg  = seg_r;

endmodule

>>> rtl/thl_div.sv
// ----------------------------------------------------------------------------
// thl_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits DIV_STEPS bits, so the upper dividend bits preload the
// partial remainder.
// ----------------------------------------------------------------------------
module thl_div import thl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic                 busy_r;
  logic                 done_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIV_STEPS-1:0] sh_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;
  logic                 ge;

  assign trial = {rem_r, sh_r[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend low bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[DIVD_W-1:DIV_STEPS];
      sh_r  <= req.dividend[DIV_STEPS-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      sh_r  <= {sh_r[DIV_STEPS-2:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = sh_r;

endmodule

>>> rtl/thermistor_table_linearizer_top.sv
// ----------------------------------------------------------------------------
// thermistor_table_linearizer_top
// ADC code to temperature in tenths of a degree: curve lookup, segment
// search and linear interpolation with truncating serial division.
//
//   channel  ports                              handshake
//   input    start, busy, in_raw_reading         beat on start & !busy
//   result   out_valid, out_temperature_tenths   one-cycle strobe, no stall
//   config   cfg_we, cfg_wdata                   write on cfg_we
//
// Out-of-range codes go from CHECK straight to DONE. Others pass through the
// bit-serial segment search, PREP and the two 8-step restoring divisions
// through the one shared divider; a zero delta goes from PREP to DONE, result 0.
// One item in flight; busy is high from accept through the result strobe, so
// the next beat can be accepted the cycle after it. The receiver cannot stall.
// Reset is synchronous, active low; sensor range resets to 3.
// ----------------------------------------------------------------------------
module thermistor_table_linearizer_top import thl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CODE_W-1:0]        in_raw_reading,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature_tenths,
  input  logic                     cfg_we,
  input  logic [RNG_W-1:0]         cfg_wdata
);

  thl_state_t state_r, state_nxt;

  logic [RNG_W-1:0]         range_r;
  logic [RNG_W-1:0]         sel_r;
  logic [CODE_W-1:0]        code_r;
  logic [PCT_W:0]           q1_r;
  logic signed [TEMP_W-1:0] base_r, base_nxt;
  logic signed [TEMP_W-1:0] res_r, res_nxt;

  logic [CV_W-1:0]          cv;
  logic [PT_W-1:0]          pt_first;
  logic [PT_W-1:0]          pt_last;
  logic [PT_W-1:0]          pt_hi;
  logic [PT_W-1:0]          pt_lo;
  logic [PT_W-1:0]          delta;
  logic [PT_W-1:0]          num;
  logic [STEP_W+SEG_W-1:0]  step_seg;
  logic                     is_high;
  logic                     is_low;

  logic                     srch_start;
  srch_stat_t               srch;
  div_req_t                 dreq;
  div_stat_t                dstat;

  assign cv       = sel_r[RNG_W-1:1];
  assign pt_first = curve_pt(cv, '0);
  assign pt_last  = curve_pt(cv, IDX_W'(SEGMENTS));
  assign is_high  = code_r <= pt_last;
  assign is_low   = code_r >= pt_first;
  assign pt_hi    = curve_pt(cv, {1'b0, srch.seg});
  assign pt_lo    = curve_pt(cv, {1'b0, srch.seg} + IDX_W'(1));
  assign delta    = pt_hi - pt_lo;
  assign num      = pt_hi - code_r;
  assign step_seg = {{SEG_W{1'b0}}, seg_step(sel_r)} * {{STEP_W{1'b0}}, srch.seg};

  thl_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .cv    (cv),
    .code  (code_r),
    .stat  (srch)
  );

  thl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .stat  (dstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      range_r <= RNG_W'(3);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        range_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      code_r <= in_raw_reading;
      sel_r  <= range_sel(range_r);
    end
    if (state_r == ST_DIV1 && dstat.done) begin
      q1_r <= dstat.quot;
    end
    base_r <= base_nxt;
    res_r  <= res_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (is_high || is_low) ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (srch.done) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = (delta == '0) ? ST_DONE : ST_DIV1;
      end
      ST_DIV1: begin
        if (dstat.done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (dstat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath: result = low + step*seg + (step * pct) / 100, a range limit when out of range, 0 when delta is 0
  always_comb begin
    base_nxt = base_r;
    res_nxt  = res_r;
    case (state_r)
      ST_CHECK: begin
        if (is_high) begin
          res_nxt = high_lim(sel_r);
        end else if (is_low) begin
          res_nxt = low_lim(sel_r);
        end
      end
      ST_PREP: begin
        base_nxt = low_lim(sel_r) + $signed({1'b0, step_seg});
        if (delta == '0) res_nxt = '0;
      end
      ST_DIV2: begin
        if (dstat.done) begin
          res_nxt = base_r + $signed({{(TEMP_W-DIV_STEPS){1'b0}}, dstat.quot});
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // outputs and unit starts
  always_comb begin
    busy          = state_r != ST_IDLE;
    out_valid     = state_r == ST_DONE;
    srch_start    = (state_r == ST_CHECK) && !is_high && !is_low;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    case (state_r)
      ST_PREP: begin
        dreq.start    = delta != '0;
        dreq.dividend = DIVD_W'(num) * DIVD_W'(HUNDRED);
        dreq.divisor  = delta;
      end
      ST_MUL: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(seg_step(sel_r)) * DIVD_W'(q1_r);
        dreq.divisor  = DIVS_W'(HUNDRED);
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  assign out_temperature_tenths = res_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider finished outside a divide state");

  a_srch_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    srch.done |-> (state_r == ST_SEARCH))
    else $error("search finished outside search state");

  a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_tenths >= low_lim(sel_r)))
    else $error("result below low limit");
`endif

endmodule
